// ===== rtl/triangle_barycentric_shader_unit_defines.svh =====
// Assertion macros for the triangle barycentric shader unit.
// Needs nothing else; included by files that carry assertions.
`ifndef TRIANGLE_BARYCENTRIC_SHADER_UNIT_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_SHADER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbs: same-cycle check failed");
`define TBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbs: next-cycle check failed");
`else
`define TBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/tbs_pkg.sv =====
// Shared constants, register codes and the configuration view type
// for the triangle barycentric shader unit. No dependencies.
package tbs_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CHANNEL_BITS = 8;
  localparam int PIX_W        = 16;
  localparam int CH_OUT_W     = 8;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_CH       = 4;
  localparam int NUM_VTX      = 3;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;
  localparam int W_W    = EDGE_W - 1;
  localparam int SUM_W  = CHANNEL_BITS + W_W;
  localparam int QUOT_W = CHANNEL_BITS;

  localparam int WGT_STAGES = 5;
  localparam int BLD_STAGES = 2;
  localparam int DIV_STAGES = QUOT_W;
  localparam int N_STAGES   = WGT_STAGES + BLD_STAGES + DIV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A,
    REG_VERTEX_B,
    REG_VERTEX_C,
    REG_COLOR_A,
    REG_COLOR_B,
    REG_COLOR_C
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [DIFF_W-1:0]     abx;
    logic signed [DIFF_W-1:0]     aby;
    logic signed [DIFF_W-1:0]     acx;
    logic signed [DIFF_W-1:0]     acy;
    logic signed [DIFF_W-1:0]     bcx;
    logic signed [DIFF_W-1:0]     bcy;
    logic signed [EDGE_W-1:0]     den;
    logic [W_W-1:0]               den_abs;
    logic [NUM_VTX-1:0][NUM_CH-1:0][CHANNEL_BITS-1:0] col;
  } cfg_view_t;

endpackage

// ===== rtl/tbs_ifs.sv =====
// Valid/ready channel interfaces: pixel positions in, shaded results out.
// Depends on tbs_pkg.
interface tbs_pixel_if import tbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface tbs_shade_if import tbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                covered;
  logic [CH_OUT_W-1:0] red;
  logic [CH_OUT_W-1:0] green;
  logic [CH_OUT_W-1:0] blue;
  logic [CH_OUT_W-1:0] alpha;

  modport source (output valid, covered, red, green, blue, alpha, input ready);
  modport sink   (input valid, covered, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/triangle_barycentric_shader_unit.sv =====
// Triangle barycentric shader top level: setup, weight, blend and divide pipeline.
// Depends on tbs_pkg, tbs_ifs, tbs_setup, tbs_weight, tbs_blend, tbs_div.
//
//   Port        Dir  Handshake     Carries
//   pixel_i     in   valid/ready   pixel_x, pixel_y
//   shade_o     out  valid/ready   covered, red, green, blue, alpha
//   cfg_*_i     in   cfg_we_i      register index and 32-bit data
//
// One pixel per cycle while shade_o is not stalled; each result passes through five
// weight stages, two blend stages and eight divider stages (one quotient bit each)
// before it is offered on shade_o.
// A stage loads when shade_o is ready or it or any later stage holds a bubble,
// so bubbles collapse under a stall; the last stage is the output register.
// Reset clears the valid bits and the setup registers; vertices and colors come up as zero.
// Derived values settle after a register write: edges, products, area, magnitude.
`include "triangle_barycentric_shader_unit_defines.svh"

module triangle_barycentric_shader_unit import tbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tbs_pixel_if.sink            pixel_i,
  tbs_shade_if.source          shade_o
);

  cfg_view_t         cfg;
  logic [N_STAGES-1:0] adv;
  logic [N_STAGES-1:0] v_q, v_in;

  logic [W_W-1:0]    weight [NUM_VTX];
  logic              wgt_cov;
  logic [SUM_W-1:0]  sum [NUM_CH];
  logic              bld_cov;
  logic [QUOT_W-1:0] quot [NUM_CH];
  logic              div_cov;

  tbs_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  for (genvar k = 0; k < N_STAGES; k++) begin : g_adv
    assign adv[k] = shade_o.ready || !(&v_q[N_STAGES-1:k]);
  end

  assign v_in = {v_q[N_STAGES-2:0], pixel_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  tbs_weight u_weight (
    .clk_i     (clk_i),
    .en_i      (adv[WGT_STAGES-1:0]),
    .cfg_i     (cfg),
    .pixel_x_i (pixel_i.pixel_x),
    .pixel_y_i (pixel_i.pixel_y),
    .weight_o  (weight),
    .covered_o (wgt_cov)
  );

  tbs_blend u_blend (
    .clk_i     (clk_i),
    .en_i      (adv[WGT_STAGES+BLD_STAGES-1:WGT_STAGES]),
    .cfg_i     (cfg),
    .weight_i  (weight),
    .covered_i (wgt_cov),
    .sum_o     (sum),
    .covered_o (bld_cov)
  );

  tbs_div u_div (
    .clk_i     (clk_i),
    .en_i      (adv[N_STAGES-1:WGT_STAGES+BLD_STAGES]),
    .den_abs_i (cfg.den_abs),
    .sum_i     (sum),
    .covered_i (bld_cov),
    .quot_o    (quot),
    .covered_o (div_cov)
  );

  assign pixel_i.ready   = adv[0];
  assign shade_o.valid   = v_q[N_STAGES-1];
  assign shade_o.covered = div_cov;
  assign shade_o.red     = CH_OUT_W'(quot[0]);
  assign shade_o.green   = CH_OUT_W'(quot[1]);
  assign shade_o.blue    = CH_OUT_W'(quot[2]);
  assign shade_o.alpha   = CH_OUT_W'(quot[3]);

  `TBS_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, pixel_i.valid && pixel_i.ready, v_q[0])
  `TBS_ASSERT_NOW(a_full_blocks, clk_i, rst_ni, (&v_q) && !shade_o.ready, !pixel_i.ready)
  `TBS_ASSERT_NOW(a_uncovered_zero, clk_i, rst_ni, shade_o.valid && !shade_o.covered,
                  {shade_o.red, shade_o.green, shade_o.blue, shade_o.alpha} == '0)
  `TBS_ASSERT_NOW(a_covered_area, clk_i, rst_ni, shade_o.valid && shade_o.covered, cfg.den_abs != '0)

endmodule

// ===== rtl/tbs_setup.sv =====
// Configuration registers and the per-triangle values derived from them
// (edge vectors, doubled area, its magnitude). Depends on tbs_pkg.
module tbs_setup import tbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_view_t            cfg_o
);

  logic [CFG_W-1:0] vtx_a_q, vtx_b_q, vtx_c_q;
  logic [CFG_W-1:0] col_a_q, col_b_q, col_c_q;

  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;

  logic signed [DIFF_W-1:0] abx_q, aby_q, acx_q, acy_q, bcx_q, bcy_q;
  logic signed [PROD_W-1:0] dp0_q, dp1_q;
  logic signed [EDGE_W-1:0] den_q, den_neg;
  logic [W_W-1:0]           den_abs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q <= '0;
      vtx_b_q <= '0;
      vtx_c_q <= '0;
      col_a_q <= '0;
      col_b_q <= '0;
      col_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTEX_A: vtx_a_q <= cfg_data_i;
        REG_VERTEX_B: vtx_b_q <= cfg_data_i;
        REG_VERTEX_C: vtx_c_q <= cfg_data_i;
        REG_COLOR_A:  col_a_q <= cfg_data_i;
        REG_COLOR_B:  col_b_q <= cfg_data_i;
        REG_COLOR_C:  col_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ax = vtx_a_q[COORD_BITS-1:0];
  assign ay = vtx_a_q[2*COORD_BITS-1 -: COORD_BITS];
  assign bx = vtx_b_q[COORD_BITS-1:0];
  assign by = vtx_b_q[2*COORD_BITS-1 -: COORD_BITS];
  assign cx = vtx_c_q[COORD_BITS-1:0];
  assign cy = vtx_c_q[2*COORD_BITS-1 -: COORD_BITS];

  assign den_neg = -den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abx_q     <= '0;
      aby_q     <= '0;
      acx_q     <= '0;
      acy_q     <= '0;
      bcx_q     <= '0;
      bcy_q     <= '0;
      dp0_q     <= '0;
      dp1_q     <= '0;
      den_q     <= '0;
      den_abs_q <= '0;
    end else begin
      abx_q     <= DIFF_W'(bx) - DIFF_W'(ax);
      aby_q     <= DIFF_W'(by) - DIFF_W'(ay);
      acx_q     <= DIFF_W'(cx) - DIFF_W'(ax);
      acy_q     <= DIFF_W'(cy) - DIFF_W'(ay);
      bcx_q     <= DIFF_W'(cx) - DIFF_W'(bx);
      bcy_q     <= DIFF_W'(cy) - DIFF_W'(by);
      dp0_q     <= abx_q * acy_q;
      dp1_q     <= aby_q * acx_q;
      den_q     <= EDGE_W'(dp0_q) - EDGE_W'(dp1_q);
      den_abs_q <= den_q[EDGE_W-1] ? den_neg[W_W-1:0] : den_q[W_W-1:0];
    end
  end

  always_comb begin
    cfg_o         = '0;
    cfg_o.ax      = ax;
    cfg_o.ay      = ay;
    cfg_o.bx      = bx;
    cfg_o.by      = by;
    cfg_o.abx     = abx_q;
    cfg_o.aby     = aby_q;
    cfg_o.acx     = acx_q;
    cfg_o.acy     = acy_q;
    cfg_o.bcx     = bcx_q;
    cfg_o.bcy     = bcy_q;
    cfg_o.den     = den_q;
    cfg_o.den_abs = den_abs_q;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cfg_o.col[0][ch] = CHANNEL_BITS'(col_a_q >> (ch * CHANNEL_BITS));
      cfg_o.col[1][ch] = CHANNEL_BITS'(col_b_q >> (ch * CHANNEL_BITS));
      cfg_o.col[2][ch] = CHANNEL_BITS'(col_c_q >> (ch * CHANNEL_BITS));
    end
  end

endmodule

// ===== rtl/tbs_weight.sv =====
// Pixel front end: coordinate differences, edge products, edge functions
// and sign-normalized barycentric weights with the coverage test. Uses tbs_pkg.
module tbs_weight import tbs_pkg::*; (
  input  logic                    clk_i,
  input  logic [WGT_STAGES-1:0]   en_i,
  input  cfg_view_t               cfg_i,
  input  logic signed [PIX_W-1:0] pixel_x_i,
  input  logic signed [PIX_W-1:0] pixel_y_i,
  output logic [W_W-1:0]          weight_o [NUM_VTX],
  output logic                    covered_o
);

  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic signed [DIFF_W-1:0]     dxa_q, dya_q, dxb_q, dyb_q;
  logic signed [PROD_W-1:0]     m_q [6];
  logic signed [EDGE_W-1:0]     e_q [NUM_VTX];
  logic [W_W-1:0]               weight_q [NUM_VTX];
  logic [W_W-1:0]               weight_d [NUM_VTX];
  logic                         covered_q, covered_d;

  // edge bc weighs vertex a, edge ac vertex b, edge ab vertex c
  always_comb begin
    logic signed [EDGE_W-1:0] n [NUM_VTX];
    logic [NUM_VTX-1:0]       pos;
    logic                     den_neg;
    den_neg = cfg_i.den[EDGE_W-1];
    for (int v = 0; v < NUM_VTX; v++) begin
      if ((v == 1) ? !den_neg : den_neg) begin
        n[v] = -e_q[v];
      end else begin
        n[v] = e_q[v];
      end
      pos[v] = !n[v][EDGE_W-1] && (n[v] != '0);
    end
    covered_d = (cfg_i.den != '0) && (&pos);
    for (int v = 0; v < NUM_VTX; v++) begin
      weight_d[v] = covered_d ? n[v][W_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= pixel_x_i[COORD_BITS-1:0];
      py_q <= pixel_y_i[COORD_BITS-1:0];
    end
    if (en_i[1]) begin
      dxa_q <= DIFF_W'(px_q) - DIFF_W'(cfg_i.ax);
      dya_q <= DIFF_W'(py_q) - DIFF_W'(cfg_i.ay);
      dxb_q <= DIFF_W'(px_q) - DIFF_W'(cfg_i.bx);
      dyb_q <= DIFF_W'(py_q) - DIFF_W'(cfg_i.by);
    end
    if (en_i[2]) begin
      m_q[0] <= cfg_i.bcx * dyb_q;
      m_q[1] <= cfg_i.bcy * dxb_q;
      m_q[2] <= cfg_i.acx * dya_q;
      m_q[3] <= cfg_i.acy * dxa_q;
      m_q[4] <= cfg_i.abx * dya_q;
      m_q[5] <= cfg_i.aby * dxa_q;
    end
    if (en_i[3]) begin
      e_q[0] <= EDGE_W'(m_q[0]) - EDGE_W'(m_q[1]);
      e_q[1] <= EDGE_W'(m_q[2]) - EDGE_W'(m_q[3]);
      e_q[2] <= EDGE_W'(m_q[4]) - EDGE_W'(m_q[5]);
    end
    if (en_i[4]) begin
      weight_q  <= weight_d;
      covered_q <= covered_d;
    end
  end

  assign weight_o  = weight_q;
  assign covered_o = covered_q;

endmodule

// ===== rtl/tbs_blend.sv =====
// Color blend: per-channel products of vertex colors and weights, then
// their sums. Uses tbs_pkg; fed by tbs_weight.
module tbs_blend import tbs_pkg::*; (
  input  logic                  clk_i,
  input  logic [BLD_STAGES-1:0] en_i,
  input  cfg_view_t             cfg_i,
  input  logic [W_W-1:0]        weight_i [NUM_VTX],
  input  logic                  covered_i,
  output logic [SUM_W-1:0]      sum_o [NUM_CH],
  output logic                  covered_o
);

  logic [SUM_W-1:0] prod_q [NUM_CH][NUM_VTX];
  logic [SUM_W-1:0] sum_q  [NUM_CH];
  logic             cov0_q, cov1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int v = 0; v < NUM_VTX; v++) begin
          prod_q[ch][v] <= SUM_W'(cfg_i.col[v][ch]) * SUM_W'(weight_i[v]);
        end
      end
      cov0_q <= covered_i;
    end
    if (en_i[1]) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum_q[ch] <= prod_q[ch][0] + prod_q[ch][1] + prod_q[ch][2];
      end
      cov1_q <= cov0_q;
    end
  end

  assign sum_o     = sum_q;
  assign covered_o = cov1_q;

endmodule

// ===== rtl/tbs_div.sv =====
// Restoring divider, one quotient bit per stage, four channel lanes.
// Divides blended sums by the magnitude of the doubled triangle area; uses tbs_pkg.
module tbs_div import tbs_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [W_W-1:0]        den_abs_i,
  input  logic [SUM_W-1:0]      sum_i [NUM_CH],
  input  logic                  covered_i,
  output logic [QUOT_W-1:0]     quot_o [NUM_CH],
  output logic                  covered_o
);

  logic [SUM_W-1:0]  rem_q [DIV_STAGES][NUM_CH];
  logic [QUOT_W-1:0] quo_q [DIV_STAGES][NUM_CH];
  logic              cov_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int Bit = QUOT_W - 1 - k;

    logic [SUM_W-1:0]  rem_in [NUM_CH];
    logic [QUOT_W-1:0] quo_in [NUM_CH];
    logic              cov_in;
    logic [SUM_W-1:0]  rem_d  [NUM_CH];
    logic [QUOT_W-1:0] quo_d  [NUM_CH];
    logic [SUM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in = sum_i;
      assign cov_in = covered_i;
      always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          quo_in[ch] = '0;
        end
      end
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign cov_in = cov_q[k-1];
    end

    assign trial = SUM_W'(den_abs_i) << Bit;

    // uncovered lanes keep a zero quotient
    always_comb begin
      logic ge;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        ge             = cov_in && (rem_in[ch] >= trial);
        rem_d[ch]      = ge ? (rem_in[ch] - trial) : rem_in[ch];
        quo_d[ch]      = quo_in[ch];
        quo_d[ch][Bit] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        cov_q[k] <= cov_in;
      end
    end
  end

  assign quot_o    = quo_q[DIV_STAGES-1];
  assign covered_o = cov_q[DIV_STAGES-1];

endmodule

// ===== verif/tbs_shade_checker.sv =====
// Scoreboard for the triangle barycentric shader unit: predicts each shaded
// result from the observed register writes and pixel transactions, then compares.
// Depends on tbs_pkg and the channel interfaces in tbs_ifs.
module tbs_shade_checker import tbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tbs_pixel_if                 pixel_i,
  tbs_shade_if                 shade_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic                covered;
    logic [CH_OUT_W-1:0] red;
    logic [CH_OUT_W-1:0] green;
    logic [CH_OUT_W-1:0] blue;
    logic [CH_OUT_W-1:0] alpha;
  } shade_t;

  logic [CFG_W-1:0] vertex_q [NUM_VTX];
  logic [CFG_W-1:0] color_q  [NUM_VTX];
  shade_t           shade_q  [$];
  int               mismatch_cnt = 0;
  int               result_idx   = 0;
  int               pending_cnt  = 0;

  assign errors_o  = mismatch_cnt;
  assign pending_o = pending_cnt;

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by,
                                    longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic longint facing(longint num, longint den);
    if (den > 0) return num;
    if (den < 0) return -num;
    return 0;
  endfunction

  function automatic shade_t shade_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    longint              ax, ay, bx, by, cx, cy, px, py;
    longint              wa, wb, wc, area, sum;
    logic [CH_OUT_W-1:0] chan [NUM_CH];
    shade_t              res;
    int                  k;
    ax = $signed(vertex_q[0][COORD_BITS-1:0]);
    ay = $signed(vertex_q[0][2*COORD_BITS-1:COORD_BITS]);
    bx = $signed(vertex_q[1][COORD_BITS-1:0]);
    by = $signed(vertex_q[1][2*COORD_BITS-1:COORD_BITS]);
    cx = $signed(vertex_q[2][COORD_BITS-1:0]);
    cy = $signed(vertex_q[2][2*COORD_BITS-1:COORD_BITS]);
    px = $signed(x);
    py = $signed(y);
    wc = facing(cross2(ax, ay, bx, by, px, py), cross2(ax, ay, bx, by, cx, cy));
    wb = facing(cross2(ax, ay, cx, cy, px, py), cross2(ax, ay, cx, cy, bx, by));
    wa = facing(cross2(bx, by, cx, cy, px, py), cross2(bx, by, cx, cy, ax, ay));
    area = cross2(ax, ay, bx, by, cx, cy);
    if (area < 0) area = -area;
    res = '0;
    if (area == 0 || wa <= 0 || wb <= 0 || wc <= 0) return res;
    for (k = 0; k < NUM_CH; k++) begin
      sum = longint'(color_q[0][k*CHANNEL_BITS +: CHANNEL_BITS]) * wa
          + longint'(color_q[1][k*CHANNEL_BITS +: CHANNEL_BITS]) * wb
          + longint'(color_q[2][k*CHANNEL_BITS +: CHANNEL_BITS]) * wc;
      chan[k] = CH_OUT_W'(sum / area);
    end
    res.covered = 1'b1;
    res.red     = chan[0];
    res.green   = chan[1];
    res.blue    = chan[2];
    res.alpha   = chan[3];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [CH_OUT_W-1:0] got,
                               input logic [CH_OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                result_idx, name, got, want));
  endtask

  always @(posedge clk_i) begin
    shade_t got;
    shade_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VTX; i++) begin
        vertex_q[i] = '0;
        color_q[i]  = '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VERTEX_A: vertex_q[0] = cfg_data_i;
          REG_VERTEX_B: vertex_q[1] = cfg_data_i;
          REG_VERTEX_C: vertex_q[2] = cfg_data_i;
          REG_COLOR_A:  color_q[0]  = cfg_data_i;
          REG_COLOR_B:  color_q[1]  = cfg_data_i;
          REG_COLOR_C:  color_q[2]  = cfg_data_i;
          default: ;
        endcase
      end
      if (pixel_i.valid && pixel_i.ready)
        shade_q.push_back(shade_pixel(pixel_i.pixel_x, pixel_i.pixel_y));
      if (shade_i.valid && shade_i.ready) begin
        got = '{shade_i.covered, shade_i.red, shade_i.green, shade_i.blue, shade_i.alpha};
        if (shade_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no pixel outstanding",
                                    result_idx));
        end else begin
          want = shade_q.pop_front();
          compare_field("covered", CH_OUT_W'(got.covered), CH_OUT_W'(want.covered));
          compare_field("red",     got.red,   want.red);
          compare_field("green",   got.green, want.green);
          compare_field("blue",    got.blue,  want.blue);
          compare_field("alpha",   got.alpha, want.alpha);
        end
        result_idx++;
      end
    end
    pending_cnt = shade_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Top of the triangle barycentric shader testbench: clock, reset, register
// loads, pixel stimulus and result back-pressure. Depends on tbs_pkg, tbs_ifs,
// the shader unit and tbs_shade_checker, which does all prediction and comparison.
module tb import tbs_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int DIRECTED      = 17;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LIMIT         = 400_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 idle_en;
  int                   stall_left = 0;
  int                   items_sent = 0;
  int                   cycle_cnt  = 0;
  int                   mismatches;
  int                   pending;

  tbs_pixel_if pix ();
  tbs_shade_if shade ();

  triangle_barycentric_shader_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pixel_i    (pix),
    .shade_o    (shade)
  );

  tbs_shade_checker shade_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pixel_i    (pix),
    .shade_i    (shade),
    .errors_o   (mismatches),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      shade.ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      shade.ready <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      shade.ready <= 1'b1;
    end
  end

  function automatic logic [CFG_W-1:0] xy(int x, int y);
    return {16'(y), 16'(x)};
  endfunction

  function automatic int clamp16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int lo3(int a, int b, int c);
    int m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int hi3(int a, int b, int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic int rand_coord();
    return $signed(16'($urandom));
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 2))
      0:       return -32768;
      1:       return 32767;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Enter and leave on a clock edge; valid stays high across back-to-back items.
  task automatic send_pixel(input int x, input int y);
    int gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= 16'(x);
    pix.pixel_y <= 16'(y);
    do @(posedge clk_i); while (!pix.ready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_triangle(input logic [CFG_W-1:0] va, input logic [CFG_W-1:0] vb,
                               input logic [CFG_W-1:0] vc, input logic [CFG_W-1:0] ca,
                               input logic [CFG_W-1:0] cb, input logic [CFG_W-1:0] cc);
    logic [CFG_W-1:0]     vals [8];
    logic [CFG_IDX_W-1:0] idxs [8];
    vals = '{va, vb, vc, ca, cb, cc, $urandom, $urandom};
    idxs = '{REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C, REG_COLOR_A, REG_COLOR_B,
             REG_COLOR_C, REG_UNUSED_LO, REG_UNUSED_HI};
    drain();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n_pix, input logic quiet);
    int ax, ay, bx, by, cx, cy, ox, oy, span, dx, dy, m;
    int lo_x, hi_x, lo_y, hi_y, px, py;
    idle_en = !quiet && ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
        ox = rand_coord();
        oy = rand_coord();
        ax = clamp16(ox + int'($urandom_range(0, 2 * span)) - span);
        ay = clamp16(oy + int'($urandom_range(0, 2 * span)) - span);
        bx = clamp16(ox + int'($urandom_range(0, 2 * span)) - span);
        by = clamp16(oy + int'($urandom_range(0, 2 * span)) - span);
        cx = clamp16(ox + int'($urandom_range(0, 2 * span)) - span);
        cy = clamp16(oy + int'($urandom_range(0, 2 * span)) - span);
      end
      5, 6: begin
        ax = rand_coord();
        ay = rand_coord();
        bx = rand_coord();
        by = rand_coord();
        cx = rand_coord();
        cy = rand_coord();
      end
      7: begin
        // collinear or coincident vertices
        span = $urandom_range(0, 20);
        ox = int'($urandom_range(0, 60000)) - 30000;
        oy = int'($urandom_range(0, 60000)) - 30000;
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        m  = int'($urandom_range(0, 4)) - 2;
        ax = ox;
        ay = oy;
        bx = ox + dx;
        by = oy + dy;
        cx = ox + m * dx;
        cy = oy + m * dy;
      end
      8: begin
        ax = corner_coord();
        ay = corner_coord();
        bx = corner_coord();
        by = corner_coord();
        cx = corner_coord();
        cy = corner_coord();
      end
      default: begin
        // sliver close to one long edge
        ax = rand_coord();
        ay = rand_coord();
        bx = rand_coord();
        by = rand_coord();
        cx = clamp16((ax + bx) / 2 + int'($urandom_range(0, 6)) - 3);
        cy = clamp16((ay + by) / 2 + int'($urandom_range(0, 6)) - 3);
      end
    endcase
    load_triangle(xy(ax, ay), xy(bx, by), xy(cx, cy), pick_color(), pick_color(),
                  pick_color());
    lo_x = lo3(ax, bx, cx);
    hi_x = hi3(ax, bx, cx);
    lo_y = lo3(ay, by, cy);
    hi_y = hi3(ay, by, cy);
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        px = lo_x + int'($urandom_range(0, hi_x - lo_x));
        py = lo_y + int'($urandom_range(0, hi_y - lo_y));
      end else begin
        px = rand_coord();
        py = rand_coord();
      end
      send_pixel(px, py);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_VERTEX_A;
    cfg_data    = '0;
    pix.valid   = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    shade.ready = 1'b0;
    idle_en     = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers out of reset form a zero-area triangle
    send_pixel(0, 0);
    send_pixel(-32768, 32767);

    load_triangle(xy(0, 0), xy(10, 0), xy(0, 10), 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h8040_2010);
    send_pixel(1, 1);
    send_pixel(3, 3);
    send_pixel(0, 0);
    send_pixel(5, 0);
    send_pixel(5, 5);
    send_pixel(-1, -1);
    send_pixel(32767, -32768);

    // opposite winding
    load_triangle(xy(0, 0), xy(0, 10), xy(10, 0), 32'h1234_5678, 32'hFF00_FF00,
                  32'h00FF_00FF);
    send_pixel(1, 1);
    send_pixel(2, 3);

    load_triangle(xy(-32768, -32768), xy(32767, -32768), xy(-32768, 32767),
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(0, 0);
    send_pixel(-32767, -32767);
    send_pixel(32767, 32767);
    send_pixel(-32768, 0);

    load_triangle(xy(1, 1), xy(2, 2), xy(3, 3), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
    send_pixel(2, 2);
    send_pixel(0, 5);

    while (items_sent < DIRECTED + RANDOM_ITEMS)
      run_phase($urandom_range(20, 70), items_sent >= DIRECTED + RANDOM_ITEMS - QUIET_TAIL);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
